>>> rtl/rw_lock_arbiter_core_assert.svh
// Assertion macros used by the lock arbiter datapath.
// Each macro expects clk and rst_n in scope.
`ifndef RW_LOCK_ARBITER_CORE_ASSERT_SVH
`define RW_LOCK_ARBITER_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define RWL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rw lock check failed");

// Consequent holds in the same cycle as the antecedent.
`define RWL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rw lock check failed");

// Consequent holds in the cycle after the antecedent.
`define RWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rw lock check failed");

`endif

>>> rtl/rwl_pkg.sv
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int MAX_WAITERS  = 16;
    localparam int TASK_ID_BITS = 8;

    localparam int TID_W   = TASK_ID_BITS;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WCNT_W  = $clog2(MAX_WAITERS + 1);
    localparam int SUM_W   = ((QCNT_W > WCNT_W) ? QCNT_W : WCNT_W) + 1;
    localparam int HOLD_W  = 8;
    localparam int REL_W   = 6;
    localparam int RATIO_W = 4;
    localparam int MODE_W  = 3;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 3;

    localparam int HOLD_MAX     = 255;
    localparam int RELEASED_MAX = 63;
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(3);

    localparam logic [MODE_W-1:0] MODE_QREAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QWRITE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WREAD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WWRITE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RUNLOCK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WUNLOCK = 3'd5;

    localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCKED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READERS  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNLOCKED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd6;

    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PREP_UNDER   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_INCONSISTENT = 3'd2;
    localparam logic [ERR_W-1:0] ERR_READ_UNDER   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NOT_WLOCKED  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW     = 3'd5;

    // What the evaluated request turns into.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SINGLE = 2'd1,
        ACT_UNLOCK = 2'd2,
        ACT_FLUSH  = 2'd3
    } act_t;

    typedef struct packed {
        logic load_req;
        logic commit;
        logic pop;
        logic woken;
        logic done;
    } rwl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic qr_zero;
        act_t act;
    } rwl_status_t;

endpackage

>>> rtl/rwl_ctrl.sv
`timescale 1ns / 1ps

module rwl_ctrl
    import rwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rwl_status_t status,
    output rwl_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_FETCH = 6'b001000,
        S_WOKEN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    unique case (status.act)
                        ACT_UNLOCK: state_next = S_DONE;
                        ACT_FLUSH:  state_next = S_FLUSH;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (status.qr_zero)
                begin
                    state_next = S_WOKEN;
                end
                else if (status.slot_free)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // wait for the new head entry to come out of the queue
                state_next = S_FLUSH;
            end
            S_WOKEN:
            begin
                if (status.slot_free)
                begin
                    cmd.woken  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.slot_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rwl_datapath.sv
`timescale 1ns / 1ps

`include "rw_lock_arbiter_core_assert.svh"

module rwl_datapath
    import rwl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rwl_cmd_t            cmd,
    output rwl_status_t         status,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TID_W-1:0]    task_id,
    input  logic                is_prepended,
    input  logic                cfg_write,
    input  logic [RATIO_W-1:0]  cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [TID_W-1:0]    task_id_out,
    output logic [WCNT_W-1:0]   woken_count,
    output logic [ERR_W-1:0]    error_code,
    output logic                last
);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (PTR_W+1)'(QUEUE_DEPTH))
            s = s - (PTR_W+1)'(QUEUE_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    // latched request
    logic [MODE_W-1:0] mode_reg;
    logic [TID_W-1:0]  tid_reg;
    logic              prep_reg;

    // lock state
    logic [RATIO_W-1:0] ratio_reg;
    logic               wh_reg, wh_next;
    logic [HOLD_W-1:0]  rh_reg, rh_next;
    logic [QCNT_W-1:0]  qr_reg, qr_next;
    logic [QCNT_W-1:0]  qw_reg, qw_next;
    logic [WCNT_W-1:0]  wrd_reg, wrd_next;
    logic [WCNT_W-1:0]  wwr_reg, wwr_next;
    logic [REL_W-1:0]   rel_reg, rel_next;
    logic [PTR_W-1:0]   rd_head_reg, rd_head_next;
    logic [PTR_W-1:0]   wr_head_reg, wr_head_next;

    logic [TID_W-1:0] reader_fifo [QUEUE_DEPTH];
    logic [TID_W-1:0] writer_fifo [QUEUE_DEPTH];
    logic [TID_W-1:0] rd_q_reg;
    logic [TID_W-1:0] wr_q_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [TID_W-1:0]  tid_out_reg;
    logic [WCNT_W-1:0] woken_reg;
    logic [ERR_W-1:0]  err_reg;
    logic              last_reg;

    // decision for the latched request
    act_t              dec_act;
    logic [ERR_W-1:0]  fault;
    logic              res_emit;
    logic [KIND_W-1:0] res_kind;
    logic [TID_W-1:0]  res_tid;
    logic              res_last;
    logic              do_hand;
    logic              push_rd, push_wr, pop_wr;
    logic              d_wh;
    logic [HOLD_W-1:0] d_rh;
    logic [QCNT_W-1:0] d_qr, d_qw;
    logic [WCNT_W-1:0] d_wrd, d_wwr;
    logic [REL_W-1:0]  d_rel;

    logic                     wr_pending, rd_pending;
    logic [SUM_W-1:0]         w_sum, r_sum;
    logic [RATIO_W+SUM_W-1:0] ratio_w;
    logic [REL_W:0]           rel_after_flush;
    logic                     flush_cond;
    logic                     commit_ok;
    logic                     out_load;
    logic                     slot_free;

    assign wr_pending = wh_reg || (qw_reg != '0) || (wwr_reg != '0);
    assign rd_pending = (qr_reg != '0) || (wrd_reg != '0) || (rel_reg != '0);
    assign w_sum      = SUM_W'(qw_reg) + SUM_W'(wwr_reg);
    assign r_sum      = SUM_W'(qr_reg) + SUM_W'(wrd_reg);
    assign ratio_w    = (RATIO_W+SUM_W)'(ratio_reg) * (RATIO_W+SUM_W)'(w_sum);
    assign rel_after_flush = (REL_W+1)'(rel_reg) + (REL_W+1)'(qr_reg);
    assign flush_cond = (r_sum != '0) &&
                        ((w_sum == '0) || ((RATIO_W+SUM_W)'(r_sum) > ratio_w));

    always_comb
    begin
        dec_act  = ACT_NONE;
        fault    = ERR_NONE;
        res_emit = 1'b0;
        res_kind = KIND_GRANTED;
        res_tid  = tid_reg;
        res_last = 1'b1;
        do_hand  = 1'b0;
        push_rd  = 1'b0;
        push_wr  = 1'b0;
        pop_wr   = 1'b0;
        d_wh     = wh_reg;
        d_rh     = rh_reg;
        d_qr     = qr_reg;
        d_qw     = qw_reg;
        d_wrd    = wrd_reg;
        d_wwr    = wwr_reg;
        d_rel    = rel_reg;
        unique case (mode_reg)
            MODE_QREAD:
            begin
                dec_act  = ACT_SINGLE;
                res_emit = 1'b1;
                if (prep_reg)
                begin
                    if (rel_reg == '0)
                        fault = ERR_PREP_UNDER;
                    else if (wh_reg || (rh_reg == '0))
                        fault = ERR_INCONSISTENT;
                    else
                        d_rel = rel_reg - REL_W'(1);
                end
                else if (wr_pending)
                begin
                    if (qr_reg >= QCNT_W'(QUEUE_DEPTH))
                        fault = ERR_OVERFLOW;
                    else
                    begin
                        push_rd  = 1'b1;
                        d_qr     = qr_reg + QCNT_W'(1);
                        res_kind = KIND_BLOCKED;
                    end
                end
                else if (rh_reg >= HOLD_W'(HOLD_MAX))
                    fault = ERR_OVERFLOW;
                else
                    d_rh = rh_reg + HOLD_W'(1);
            end
            MODE_QWRITE:
            begin
                dec_act  = ACT_SINGLE;
                res_emit = 1'b1;
                if (prep_reg)
                begin
                    if (rel_reg == '0)
                        fault = ERR_PREP_UNDER;
                    else if ((rh_reg != '0) || !wh_reg)
                        fault = ERR_INCONSISTENT;
                    else
                        d_rel = rel_reg - REL_W'(1);
                end
                else if (wr_pending || (rh_reg != '0))
                begin
                    if (qw_reg >= QCNT_W'(QUEUE_DEPTH))
                        fault = ERR_OVERFLOW;
                    else
                    begin
                        push_wr  = 1'b1;
                        d_qw     = qw_reg + QCNT_W'(1);
                        res_kind = KIND_BLOCKED;
                    end
                end
                else if (rd_pending)
                    fault = ERR_INCONSISTENT;
                else
                    d_wh = 1'b1;
            end
            MODE_WREAD:
            begin
                dec_act  = ACT_SINGLE;
                res_emit = 1'b1;
                if (wr_pending)
                begin
                    if (wrd_reg >= WCNT_W'(MAX_WAITERS))
                        fault = ERR_OVERFLOW;
                    else
                    begin
                        d_wrd    = wrd_reg + WCNT_W'(1);
                        res_kind = KIND_BLOCKED;
                    end
                end
                else if (rh_reg >= HOLD_W'(HOLD_MAX))
                    fault = ERR_OVERFLOW;
                else
                    d_rh = rh_reg + HOLD_W'(1);
            end
            MODE_WWRITE:
            begin
                dec_act  = ACT_SINGLE;
                res_emit = 1'b1;
                if (wr_pending || (rh_reg != '0))
                begin
                    if (wwr_reg >= WCNT_W'(MAX_WAITERS))
                        fault = ERR_OVERFLOW;
                    else
                    begin
                        d_wwr    = wwr_reg + WCNT_W'(1);
                        res_kind = KIND_BLOCKED;
                    end
                end
                else if (rd_pending)
                    fault = ERR_INCONSISTENT;
                else
                    d_wh = 1'b1;
            end
            MODE_RUNLOCK:
            begin
                dec_act = ACT_UNLOCK;
                if (rh_reg == '0)
                    fault = ERR_READ_UNDER;
                else if ((rh_reg == HOLD_W'(1)) && (qw_reg != '0) &&
                         ((rel_reg != '0) || wh_reg))
                    fault = ERR_INCONSISTENT;
                else
                begin
                    d_rh    = rh_reg - HOLD_W'(1);
                    do_hand = (rh_reg == HOLD_W'(1));
                end
            end
            MODE_WUNLOCK:
            begin
                if (!wh_reg)
                    fault = ERR_NOT_WLOCKED;
                else if (flush_cond)
                begin
                    // two bounded queues together stay under the hold limit
                    dec_act = ACT_FLUSH;
                    if (rel_after_flush > (REL_W+1)'(RELEASED_MAX))
                        fault = ERR_OVERFLOW;
                    else
                    begin
                        d_wh = 1'b0;
                        d_rh = HOLD_W'(r_sum);
                    end
                end
                else
                begin
                    dec_act = ACT_UNLOCK;
                    if ((qw_reg != '0) && (rel_reg != '0))
                        fault = ERR_INCONSISTENT;
                    else
                    begin
                        d_wh    = 1'b0;
                        do_hand = 1'b1;
                    end
                end
            end
            default:
            begin
                dec_act = ACT_NONE;
            end
        endcase

        // hand the freed lock to the head writer task, else to a waiting writer
        if (do_hand)
        begin
            if (qw_reg != '0)
            begin
                pop_wr   = 1'b1;
                d_qw     = qw_reg - QCNT_W'(1);
                d_wh     = 1'b1;
                d_rel    = rel_reg + REL_W'(1);
                res_emit = 1'b1;
                res_kind = KIND_RELEASED;
                res_tid  = wr_q_reg;
                res_last = 1'b0;
            end
            else if (wwr_reg != '0)
            begin
                d_wwr    = wwr_reg - WCNT_W'(1);
                d_wh     = 1'b1;
                res_emit = 1'b1;
                res_kind = KIND_WRITER;
                res_last = 1'b0;
            end
        end

        if (fault != ERR_NONE)
        begin
            dec_act  = ACT_SINGLE;
            res_emit = 1'b1;
            res_kind = KIND_ERROR;
            res_tid  = tid_reg;
            res_last = 1'b1;
        end
    end

    assign commit_ok = cmd.commit && (fault == ERR_NONE);
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = (cmd.commit && res_emit) || cmd.pop || cmd.woken || cmd.done;

    always_comb
    begin
        wh_next      = wh_reg;
        rh_next      = rh_reg;
        qr_next      = qr_reg;
        qw_next      = qw_reg;
        wrd_next     = wrd_reg;
        wwr_next     = wwr_reg;
        rel_next     = rel_reg;
        rd_head_next = rd_head_reg;
        wr_head_next = wr_head_reg;
        if (commit_ok)
        begin
            wh_next  = d_wh;
            rh_next  = d_rh;
            qr_next  = d_qr;
            qw_next  = d_qw;
            wrd_next = d_wrd;
            wwr_next = d_wwr;
            rel_next = d_rel;
            if (pop_wr)
                wr_head_next = ptr_inc(wr_head_reg);
        end
        if (cmd.pop)
        begin
            qr_next      = qr_reg - QCNT_W'(1);
            rel_next     = rel_reg + REL_W'(1);
            rd_head_next = ptr_inc(rd_head_reg);
        end
        if (cmd.woken)
            wrd_next = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            wh_reg        <= 1'b0;
            rh_reg        <= '0;
            qr_reg        <= '0;
            qw_reg        <= '0;
            wrd_reg       <= '0;
            wwr_reg       <= '0;
            rel_reg       <= '0;
            rd_head_reg   <= '0;
            wr_head_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                ratio_reg <= cfg_data;
            wh_reg        <= wh_next;
            rh_reg        <= rh_next;
            qr_reg        <= qr_next;
            qw_reg        <= qw_next;
            wrd_reg       <= wrd_next;
            wwr_reg       <= wwr_next;
            rel_reg       <= rel_next;
            rd_head_reg   <= rd_head_next;
            wr_head_reg   <= wr_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= mode;
            tid_reg  <= task_id;
            prep_reg <= is_prepended;
        end
        if (out_load)
        begin
            priority if (cmd.commit)
            begin
                kind_reg    <= res_kind;
                tid_out_reg <= res_tid;
                woken_reg   <= '0;
                err_reg     <= fault;
                last_reg    <= res_last;
            end
            else if (cmd.pop)
            begin
                kind_reg    <= KIND_RELEASED;
                tid_out_reg <= rd_q_reg;
                woken_reg   <= '0;
                err_reg     <= ERR_NONE;
                last_reg    <= 1'b0;
            end
            else if (cmd.woken)
            begin
                kind_reg    <= KIND_READERS;
                tid_out_reg <= tid_reg;
                woken_reg   <= wrd_reg;
                err_reg     <= ERR_NONE;
                last_reg    <= 1'b0;
            end
            else
            begin
                kind_reg    <= KIND_UNLOCKED;
                tid_out_reg <= tid_reg;
                woken_reg   <= '0;
                err_reg     <= ERR_NONE;
                last_reg    <= 1'b1;
            end
        end
    end

    // task queues: write at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (commit_ok && push_rd)
            reader_fifo[ptr_add(rd_head_reg, qr_reg[PTR_W-1:0])] <= tid_reg;
        if (commit_ok && push_wr)
            writer_fifo[ptr_add(wr_head_reg, qw_reg[PTR_W-1:0])] <= tid_reg;
        rd_q_reg <= reader_fifo[rd_head_reg];
        wr_q_reg <= writer_fifo[wr_head_reg];
    end

    assign status.slot_free = slot_free;
    assign status.qr_zero   = (qr_reg == '0);
    assign status.act       = dec_act;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign task_id_out = tid_out_reg;
    assign woken_count = woken_reg;
    assign error_code  = err_reg;
    assign last        = last_reg;

    `RWL_ASSERT_ALWAYS(a_excl_hold, !(wh_reg && (rh_reg != '0)))
    `RWL_ASSERT_IMPL(a_load_free, out_load, slot_free)
    `RWL_ASSERT_IMPL(a_pop_nonempty, cmd.pop, qr_reg != '0)
    `RWL_ASSERT_NEXT(a_pop_advance, cmd.pop, rd_head_reg != $past(rd_head_reg))

endmodule

>>> rtl/rw_lock_arbiter_core.sv
`timescale 1ns / 1ps

// Lock and wait requests: latched on accept, evaluated, result registered; the next may enter while it waits.
// Unlocks: optional hand-over result, then the done result.
// Reader flush: each queued reader, the woken count, then done.
// Faults and unknown modes end after evaluation. A full result register stalls.
// Reset (rst_n low, asynchronous): lock free, all counts and queues empty, ratio 3.
// Queue contents are not cleared; only entries that were written are ever read.

module rw_lock_arbiter_core
    import rwl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [TID_W-1:0]   task_id,
    input  logic               is_prepended,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [TID_W-1:0]   task_id_out,
    output logic [WCNT_W-1:0]  woken_count,
    output logic [ERR_W-1:0]   error_code,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RATIO_W-1:0] cfg_data
);

    rwl_cmd_t    cmd;
    rwl_status_t status;

    assign cfg_ready = 1'b1;

    rwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rwl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .task_id      (task_id),
        .is_prepended (is_prepended),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .task_id_out  (task_id_out),
        .woken_count  (woken_count),
        .error_code   (error_code),
        .last         (last)
    );

endmodule

>>> test/rw_lock_arbiter_core_test.sv
`timescale 1ns / 1ps

module rw_lock_arbiter_core_test;
    import rwl_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  tid;
        logic [WCNT_W-1:0] woken;
        logic [ERR_W-1:0]  err;
        logic              last;
    } lock_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode = MODE_QREAD;
    logic [TID_W-1:0]   task_id = '0;
    logic               is_prepended = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [TID_W-1:0]   task_id_out;
    logic [WCNT_W-1:0]  woken_count;
    logic [ERR_W-1:0]   error_code;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [RATIO_W-1:0] cfg_data = '0;

    // Lock state as predicted
    logic               wr_held;
    int unsigned        rd_held;
    int unsigned        waiting_rd;
    int unsigned        waiting_wr;
    int unsigned        released_tasks;
    logic [TID_W-1:0]   reader_tasks[$];
    logic [TID_W-1:0]   writer_tasks[$];
    logic [RATIO_W-1:0] flush_ratio;

    lock_result_t       step_results[$];
    lock_result_t       expected_results[$];

    int                 fail_count = 0;
    int                 results_seen = 0;
    int                 idle_cycles = 0;
    int                 hold_count = 0;
    logic               hold_off = 1'b0;
    logic               no_idle = 1'b0;

    rw_lock_arbiter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .task_id      (task_id),
        .is_prepended (is_prepended),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .task_id_out  (task_id_out),
        .woken_count  (woken_count),
        .error_code   (error_code),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void add_result(input logic [KIND_W-1:0] k, input logic [TID_W-1:0] tid,
                                       input logic [WCNT_W-1:0] woken,
                                       input logic [ERR_W-1:0] err);
        lock_result_t r;
        r.kind  = k;
        r.tid   = tid;
        r.woken = woken;
        r.err   = err;
        r.last  = 1'b0;
        step_results.push_back(r);
    endfunction

    // Give a freed lock to the head queued writer task, else to one waiting writer.
    function automatic void hand_lock_to_writer(input logic [TID_W-1:0] tid);
        if (writer_tasks.size() != 0) begin
            add_result(KIND_RELEASED, writer_tasks.pop_front(), '0, ERR_NONE);
            wr_held = 1'b1;
            released_tasks++;
        end
        else if (waiting_wr != 0) begin
            waiting_wr--;
            wr_held = 1'b1;
            add_result(KIND_WRITER, tid, '0, ERR_NONE);
        end
    endfunction

    function automatic void apply_lock_request(input logic [MODE_W-1:0] m,
                                               input logic [TID_W-1:0] tid, input logic prep);
        logic        wr_busy;
        logic        rd_busy;
        int unsigned w;
        int unsigned r;
        wr_busy = wr_held || writer_tasks.size() != 0 || waiting_wr != 0;
        rd_busy = reader_tasks.size() != 0 || waiting_rd != 0 || released_tasks != 0;
        w = writer_tasks.size() + waiting_wr;
        r = reader_tasks.size() + waiting_rd;
        step_results.delete();
        case (m)
            MODE_QREAD:
                if (prep) begin
                    if (released_tasks == 0)
                        add_result(KIND_ERROR, tid, '0, ERR_PREP_UNDER);
                    else if (wr_held || rd_held == 0)
                        add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                    else begin
                        released_tasks--;
                        add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                    end
                end
                else if (wr_busy) begin
                    if (reader_tasks.size() >= QUEUE_DEPTH)
                        add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                    else begin
                        reader_tasks.push_back(tid);
                        add_result(KIND_BLOCKED, tid, '0, ERR_NONE);
                    end
                end
                else if (rd_held >= HOLD_MAX)
                    add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                else begin
                    rd_held++;
                    add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                end
            MODE_QWRITE:
                if (prep) begin
                    if (released_tasks == 0)
                        add_result(KIND_ERROR, tid, '0, ERR_PREP_UNDER);
                    else if (rd_held != 0 || !wr_held)
                        add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                    else begin
                        released_tasks--;
                        add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                    end
                end
                else if (wr_busy || rd_held != 0) begin
                    if (writer_tasks.size() >= QUEUE_DEPTH)
                        add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                    else begin
                        writer_tasks.push_back(tid);
                        add_result(KIND_BLOCKED, tid, '0, ERR_NONE);
                    end
                end
                else if (rd_busy)
                    add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                else begin
                    wr_held = 1'b1;
                    add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                end
            MODE_WREAD:
                if (wr_busy) begin
                    if (waiting_rd >= MAX_WAITERS)
                        add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                    else begin
                        waiting_rd++;
                        add_result(KIND_BLOCKED, tid, '0, ERR_NONE);
                    end
                end
                else if (rd_held >= HOLD_MAX)
                    add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                else begin
                    rd_held++;
                    add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                end
            MODE_WWRITE:
                if (wr_busy || rd_held != 0) begin
                    if (waiting_wr >= MAX_WAITERS)
                        add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                    else begin
                        waiting_wr++;
                        add_result(KIND_BLOCKED, tid, '0, ERR_NONE);
                    end
                end
                else if (rd_busy)
                    add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                else begin
                    wr_held = 1'b1;
                    add_result(KIND_GRANTED, tid, '0, ERR_NONE);
                end
            MODE_RUNLOCK:
                if (rd_held == 0)
                    add_result(KIND_ERROR, tid, '0, ERR_READ_UNDER);
                else if (rd_held == 1 && writer_tasks.size() != 0 &&
                         (released_tasks != 0 || wr_held))
                    add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                else begin
                    rd_held--;
                    if (rd_held == 0)
                        hand_lock_to_writer(tid);
                    add_result(KIND_UNLOCKED, tid, '0, ERR_NONE);
                end
            MODE_WUNLOCK:
                if (!wr_held)
                    add_result(KIND_ERROR, tid, '0, ERR_NOT_WLOCKED);
                else if (r != 0 && (w == 0 || r > int'(flush_ratio) * w)) begin
                    // Flush every waiting reader
                    if (released_tasks + reader_tasks.size() > RELEASED_MAX || r > HOLD_MAX)
                        add_result(KIND_ERROR, tid, '0, ERR_OVERFLOW);
                    else begin
                        wr_held = 1'b0;
                        rd_held = r;
                        while (reader_tasks.size() != 0) begin
                            add_result(KIND_RELEASED, reader_tasks.pop_front(), '0, ERR_NONE);
                            released_tasks++;
                        end
                        add_result(KIND_READERS, tid, WCNT_W'(waiting_rd), ERR_NONE);
                        waiting_rd = 0;
                        add_result(KIND_UNLOCKED, tid, '0, ERR_NONE);
                    end
                end
                else if (writer_tasks.size() != 0 && released_tasks != 0)
                    add_result(KIND_ERROR, tid, '0, ERR_INCONSISTENT);
                else begin
                    wr_held = 1'b0;
                    hand_lock_to_writer(tid);
                    add_result(KIND_UNLOCKED, tid, '0, ERR_NONE);
                end
            default:
                ;
        endcase
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Check each result against the oldest prediction; also watch for a hang.
    always @(posedge clk)
    begin
        lock_result_t got;
        lock_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.kind  = kind;
                got.tid   = task_id_out;
                got.woken = woken_count;
                got.err   = error_code;
                got.last  = last;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing pending: kind %0d tid %02h",
                                              results_seen, got.kind, got.tid));
                else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.tid !== want.tid ||
                        got.woken !== want.woken || got.err !== want.err ||
                        got.last !== want.last)
                        report_mismatch({
                            $sformatf("result %0d: got kind %0d tid %02h woken %0d err %0d",
                                      results_seen, got.kind, got.tid, got.woken, got.err),
                            $sformatf(" last %0b, want kind %0d tid %02h woken %0d err %0d",
                                      got.last, want.kind, want.tid, want.woken, want.err),
                            $sformatf(" last %0b", want.last)});
                end
                results_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: random stalls, a steady stretch, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off) begin
            out_ready <= 1'b0;
            if (hold_count == HOLD_OFF_CYCLES - 1) begin
                hold_off <= 1'b0;
                hold_count = 0;
            end
            else
                hold_count++;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 35);
    end

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [TID_W-1:0] tid,
                                input logic prep);
        if (!no_idle && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        task_id      <= tid;
        is_prepended <= prep;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_lock_request(m, tid, prep);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_flush_ratio(input logic [RATIO_W-1:0] ratio);
        drain_results();
        // a dropped unknown mode may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ratio;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        flush_ratio = ratio;
    endtask

    // Mostly requests that fit the current lock state, some raw noise.
    task automatic pick_request(output logic [MODE_W-1:0] m, output logic [TID_W-1:0] tid,
                                output logic prep);
        int roll;
        roll = $urandom_range(99);
        tid  = TID_W'($urandom);
        prep = 1'b0;
        if (roll < 15) begin
            m    = MODE_W'($urandom_range(7));
            prep = 1'($urandom_range(1));
        end
        else if (released_tasks != 0 && roll < 45) begin
            prep = 1'b1;
            m    = wr_held ? MODE_QWRITE : MODE_QREAD;
        end
        else begin
            case ($urandom_range(5))
                0: m = MODE_QREAD;
                1: m = MODE_WREAD;
                2: m = MODE_QWRITE;
                3: m = MODE_WWRITE;
                default:
                    if (wr_held)
                        m = MODE_WUNLOCK;
                    else if (rd_held != 0)
                        m = MODE_RUNLOCK;
                    else
                        m = MODE_WWRITE;
            endcase
        end
    endtask

    task automatic test_lock_handover();
        send_request(MODE_QWRITE,  8'hFF, 1'b0);
        send_request(MODE_QREAD,   8'h00, 1'b0);
        send_request(MODE_WREAD,   8'h5A, 1'b0);
        send_request(MODE_QWRITE,  8'hA5, 1'b0);
        send_request(MODE_WWRITE,  8'h3C, 1'b0);
        send_request(MODE_WUNLOCK, 8'h81, 1'b0);
        send_request(MODE_QWRITE,  8'hA5, 1'b1);
        send_request(MODE_WUNLOCK, 8'h42, 1'b0);
        send_request(MODE_WUNLOCK, 8'h24, 1'b0);
        send_request(MODE_QREAD,   8'h00, 1'b1);
        send_request(MODE_RUNLOCK, 8'h5A, 1'b0);
        send_request(MODE_RUNLOCK, 8'h00, 1'b0);
    endtask

    task automatic test_faults();
        send_request(MODE_RUNLOCK, 8'h11, 1'b0);
        send_request(MODE_WUNLOCK, 8'h22, 1'b0);
        send_request(MODE_QREAD,   8'h33, 1'b1);
        send_request(3'd7,         8'h44, 1'b1);
        // flush one reader, then drop the read lock before its task picks it up
        send_request(MODE_WWRITE,  8'h01, 1'b0);
        send_request(MODE_QREAD,   8'h02, 1'b0);
        send_request(MODE_WUNLOCK, 8'h04, 1'b0);
        send_request(MODE_RUNLOCK, 8'h05, 1'b0);
        send_request(MODE_WWRITE,  8'h06, 1'b0);
        send_request(MODE_QREAD,   8'h07, 1'b0);
        send_request(MODE_QWRITE,  8'h08, 1'b0);
        send_request(MODE_RUNLOCK, 8'h09, 1'b0);
        send_request(MODE_QREAD,   8'h02, 1'b1);
        send_request(MODE_RUNLOCK, 8'h0A, 1'b0);
        send_request(MODE_QWRITE,  8'h08, 1'b1);
        send_request(MODE_WUNLOCK, 8'h0B, 1'b0);
    endtask

    // Fill the reader queue past its depth while results are held back.
    task automatic test_reader_flood();
        drain_results();
        hold_off <= 1'b1;
        send_request(MODE_WWRITE, 8'hC3, 1'b0);
        repeat (QUEUE_DEPTH + 1)
            send_request(MODE_QREAD, TID_W'($urandom), 1'b0);
        send_request(MODE_WREAD, 8'h7E, 1'b0);
        send_request(MODE_WUNLOCK, 8'hC3, 1'b0);
        drain_results();
    endtask

    task automatic test_random_requests(input int count, input logic steady);
        int               sent;
        int               burst;
        logic [MODE_W-1:0] m;
        logic [TID_W-1:0]  tid;
        logic              prep;
        sent = 0;
        no_idle <= steady;
        while (sent < count) begin
            if (wr_held && $urandom_range(99) < 12) begin
                burst = $urandom_range(6, 18);
                repeat (burst) begin
                    send_request(($urandom_range(99) < 60) ? MODE_QREAD : MODE_WREAD,
                                 TID_W'($urandom), 1'b0);
                    sent++;
                end
            end
            else begin
                pick_request(m, tid, prep);
                send_request(m, tid, prep);
                if (m <= MODE_WUNLOCK)
                    sent++;
            end
        end
        drain_results();
        no_idle <= 1'b0;
    endtask

    initial
    begin
        wr_held        = 1'b0;
        rd_held        = 0;
        waiting_rd     = 0;
        waiting_wr     = 0;
        released_tasks = 0;
        flush_ratio    = RATIO_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lock_handover();
        test_faults();
        test_reader_flood();
        write_flush_ratio(4'd0);
        test_random_requests(25, 1'b1);
        write_flush_ratio(4'd15);
        test_random_requests(28, 1'b0);
        write_flush_ratio(4'd1);
        test_random_requests(28, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
